// ===== hdl/fba_pkg.sv =====
// Shared types, constants and a helper function of the frame bitmap allocator.
`default_nettype none
package fba_pkg;

	// Default number of frames that the bitmap store covers.
	localparam int MAX_FRAMES_DEFAULT = 32768;

	// Bits in one bitmap word, and the frame shift of a byte address.
	localparam int WORD_BITS   = 32;
	localparam int FRAME_SHIFT = 12;
	localparam int ADDR_W      = 32;
	localparam int FRAME_W     = ADDR_W - FRAME_SHIFT;

	// Configuration register.
	localparam int           LIMIT_W           = 16;
	localparam logic [15:0]  FRAME_LIMIT_RESET = 16'd32768;

	// Width of the reported free frame number.
	localparam int FREE_FRAME_W = 15;

	typedef enum logic [1:0] {
		CMD_SET   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_TEST  = 2'd2,
		CMD_FIND  = 2'd3
	} fba_cmd_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW,
		ST_SCAN
	} fba_state_t;

	typedef struct packed {
		fba_cmd_t            command;
		logic [ADDR_W-1:0]   frame_address;
	} fba_item_t;

	typedef struct packed {
		logic                    bit_value;
		logic                    found;
		logic [FREE_FRAME_W-1:0] free_frame;
		logic                    out_of_range;
	} fba_result_t;

	// Position of the lowest clear bit of a word; zero if every bit is set.
	function automatic logic [4:0] fba_lowest_zero(input logic [WORD_BITS-1:0] w);
		logic [4:0] pos;
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!w[i]) begin
				pos = 5'(i);
			end
		end
		return pos;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/frame_bitmap_allocator_unit.sv =====
// Top level of the frame bitmap allocator: limit register, bitmap store and sequencer.
`default_nettype none
// The block keeps one used bit per 4 KiB frame in a single-port-read bitmap store of
// MAX_FRAMES/32 words of 32 bits. After reset it runs a clearing pass over every word
// with busy high; then a command is taken at a clock edge where start is high and busy
// is low. Set, clear and test read the word from idle; in the read-modify-write state
// set and clear write it back and test reports the bit. A set, clear or test whose
// frame is at or beyond the limit changes nothing and finishes straight from idle with
// out_of_range high. Find reads one word per cycle through the store's one read port,
// from word 0 up to the last whole word below the limit, at most limit/32 words, and
// stops at the first word with a clear bit; with a limit below 32 frames it finishes
// straight from idle with found low. Each result is put on result, marked by done high
// for exactly one cycle, the cycle after its command finishes; there is no way to hold
// it, so the receiver must take every transfer as it comes. The frame limit above
// MAX_FRAMES acts as MAX_FRAMES, and it may be written only while the block is idle.
module frame_bitmap_allocator_unit #(
	parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEFAULT
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire fba_pkg::fba_item_t            item,
	output logic                               busy,
	output logic                               done,
	output fba_pkg::fba_result_t               result,
	input  wire logic                          limit_we,
	input  wire logic [fba_pkg::LIMIT_W-1:0]   limit_wdata
);

	localparam int MAP_WORDS = (MAX_FRAMES + 31) / 32;
	localparam int IDX_W     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int LIM_W     = $clog2(MAX_FRAMES + 1);

	logic [fba_pkg::LIMIT_W-1:0]   limit_q;
	logic [LIM_W-1:0]              lim_eff;
	logic                          ram_we;
	logic [IDX_W-1:0]              ram_waddr;
	logic [IDX_W-1:0]              ram_raddr;
	logic [fba_pkg::WORD_BITS-1:0] ram_wdata;
	logic [fba_pkg::WORD_BITS-1:0] ram_rdata;

	// Frame limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= fba_pkg::FRAME_LIMIT_RESET;
		end else if (limit_we) begin
			limit_q <= limit_wdata;
		end
	end

	// A limit above the store's capacity is clamped to the capacity.
	assign lim_eff = (32'(limit_q) > 32'(MAX_FRAMES)) ? LIM_W'(MAX_FRAMES) : LIM_W'(limit_q);

	fba_ram #(
		.DEPTH (MAP_WORDS),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fba_ctrl #(
		.MAX_FRAMES (MAX_FRAMES),
		.MAP_WORDS  (MAP_WORDS),
		.IDX_W      (IDX_W),
		.LIM_W      (LIM_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.lim_eff   (lim_eff),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

endmodule
`default_nettype wire

// ===== hdl/fba_ram.sv =====
// Bitmap word store: one write port and one registered read port.
`default_nettype none
module fba_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [AW-1:0]                  waddr,
	input  wire logic [fba_pkg::WORD_BITS-1:0]  wdata,
	input  wire logic [AW-1:0]                  raddr,
	output logic      [fba_pkg::WORD_BITS-1:0]  rdata
);

	logic [fba_pkg::WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/fba_ctrl.sv =====
// Command sequencer: clearing pass, read-modify-write and word-by-word free-frame scan.
`default_nettype none
module fba_ctrl #(
	parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEFAULT,
	parameter int MAP_WORDS  = (MAX_FRAMES + 31) / 32,
	parameter int IDX_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
	parameter int LIM_W      = $clog2(MAX_FRAMES + 1)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire fba_pkg::fba_item_t             item,
	input  wire logic [LIM_W-1:0]               lim_eff,
	output logic                                busy,
	output logic                                done,
	output fba_pkg::fba_result_t                result,
	output logic                                ram_we,
	output logic      [IDX_W-1:0]               ram_waddr,
	output logic      [fba_pkg::WORD_BITS-1:0]  ram_wdata,
	output logic      [IDX_W-1:0]               ram_raddr,
	input  wire logic [fba_pkg::WORD_BITS-1:0]  ram_rdata
);

	localparam int WCNT_W = $clog2(MAP_WORDS + 1);

	fba_pkg::fba_state_t  state_q, state_d;
	logic [IDX_W-1:0]     ptr_q, ptr_d;
	logic [IDX_W-1:0]     ptr_inc;
	logic [WCNT_W-1:0]    ptr_cnt_next;
	logic [WCNT_W-1:0]    words;
	fba_pkg::fba_cmd_t    cmd_q;
	logic [4:0]           bitpos_q;
	logic                 done_q;
	fba_pkg::fba_result_t res_q, res_d;
	logic                 load_res;
	logic [fba_pkg::FRAME_W-1:0] frame;
	logic                 frame_oor;
	logic [IDX_W-1:0]     frame_idx;
	logic [fba_pkg::WORD_BITS-1:0] bit_mask;
	logic                 accept;

	assign frame        = item.frame_address[fba_pkg::ADDR_W-1:fba_pkg::FRAME_SHIFT];
	assign frame_oor    = 32'(frame) >= 32'(lim_eff);
	assign frame_idx    = frame[5 +: IDX_W];
	assign words        = WCNT_W'(lim_eff >> 5);
	assign ptr_inc      = IDX_W'(ptr_q + IDX_W'(1));
	assign ptr_cnt_next = WCNT_W'(ptr_q) + WCNT_W'(1);
	assign bit_mask     = fba_pkg::WORD_BITS'(1) << bitpos_q;
	assign busy         = (state_q != fba_pkg::ST_IDLE);
	assign accept       = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fba_pkg::ST_CLEAR;
			ptr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			done_q  <= load_res;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= item.command;
			bitpos_q <= frame[4:0];
		end
		if (load_res) begin
			res_q <= res_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = '0;
		ram_raddr = ptr_q;
		load_res  = 1'b0;
		res_d     = '0;
		unique case (state_q)
			fba_pkg::ST_CLEAR: begin
				ram_we = 1'b1;
				if (WCNT_W'(ptr_q) == WCNT_W'(MAP_WORDS - 1)) begin
					ptr_d   = '0;
					state_d = fba_pkg::ST_IDLE;
				end else begin
					ptr_d = ptr_inc;
				end
			end
			fba_pkg::ST_IDLE: begin
				ram_raddr = (item.command == fba_pkg::CMD_FIND) ? '0 : frame_idx;
				if (start) begin
					if (item.command == fba_pkg::CMD_FIND) begin
						if (words == '0) begin
							load_res = 1'b1;
						end else begin
							ptr_d   = '0;
							state_d = fba_pkg::ST_SCAN;
						end
					end else if (frame_oor) begin
						load_res           = 1'b1;
						res_d.out_of_range = 1'b1;
					end else begin
						ptr_d   = frame_idx;
						state_d = fba_pkg::ST_RMW;
					end
				end
			end
			fba_pkg::ST_RMW: begin
				load_res = 1'b1;
				state_d  = fba_pkg::ST_IDLE;
				unique case (cmd_q)
					fba_pkg::CMD_SET: begin
						ram_we    = 1'b1;
						ram_wdata = ram_rdata | bit_mask;
					end
					fba_pkg::CMD_CLEAR: begin
						ram_we    = 1'b1;
						ram_wdata = ram_rdata & ~bit_mask;
					end
					fba_pkg::CMD_TEST: begin
						res_d.bit_value = |(ram_rdata & bit_mask);
					end
					fba_pkg::CMD_FIND: begin
						res_d = '0;
					end
				endcase
			end
			fba_pkg::ST_SCAN: begin
				ram_raddr = ptr_inc;
				if (ram_rdata != '1) begin
					load_res         = 1'b1;
					res_d.found      = 1'b1;
					res_d.free_frame = fba_pkg::FREE_FRAME_W'(
						{ptr_q, fba_pkg::fba_lowest_zero(ram_rdata)});
					state_d          = fba_pkg::ST_IDLE;
				end else if (ptr_cnt_next == words) begin
					load_res = 1'b1;
					state_d  = fba_pkg::ST_IDLE;
				end else begin
					ptr_d = ptr_inc;
				end
			end
			default: begin
				state_d = fba_pkg::ST_IDLE;
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

	// The store is written only by the clearing pass and by a write-back.
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == fba_pkg::ST_CLEAR || state_q == fba_pkg::ST_RMW))
		else $error("bitmap write outside clearing pass or write-back");

	// Every cycle in the read-modify-write state is followed in the next cycle by done.
	a_rmw_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fba_pkg::ST_RMW) |=> done_q)
		else $error("read-modify-write produced no result");

	// The scan pointer never reaches the whole-word count.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fba_pkg::ST_SCAN) |-> (WCNT_W'(ptr_q) < words))
		else $error("scan pointer beyond the frame limit");

	// An out-of-range result is only produced straight from idle.
	a_oor_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.out_of_range) |-> ($past(state_q) == fba_pkg::ST_IDLE))
		else $error("out-of-range result not from idle");

endmodule
`default_nettype wire
